// ----- rtl/core/ugc_pkg.sv -----
// Package for the up/down gesture classifier.
// Holds payload structs, threshold bundle, register indexes and gesture codes.
// No dependencies.
`default_nettype none

package ugc_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 1'b1;

  localparam logic [7:0] HIGH_THR_RST = 8'd64;
  localparam logic [7:0] LOW_THR_RST  = 8'd32;

  localparam logic [1:0] DECIDE_COUNT = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_END    = 1'b1;

  typedef enum logic [1:0] {
    GEST_NONE = 2'd0,
    GEST_UP   = 2'd1,
    GEST_DOWN = 2'd2
  } gesture_t;

  typedef struct packed {
    logic       func;
    logic [7:0] up_reading;
    logic [7:0] down_reading;
  } ugc_in_t;

  typedef struct packed {
    logic       event_res;
    logic [1:0] gesture;
  } ugc_out_t;

  typedef struct packed {
    logic [7:0] high;
    logic [7:0] low;
  } ugc_thr_t;

endpackage

`default_nettype wire

// ----- rtl/core/ugc_cfg_regs.sv -----
// Threshold register file of the up/down gesture classifier.
// Depends on ugc_pkg for register indexes and reset values.
`default_nettype none

module ugc_cfg_regs
  import ugc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output      ugc_thr_t             thr
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.high <= HIGH_THR_RST;
      thr.low  <= LOW_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIGH_THR: thr.high <= cfg_data;
        REG_LOW_THR:  thr.low  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ugc_classify.sv -----
// Stream state and per-item classification logic.
// Depends on ugc_pkg; the result is combinational from the held item and state.
`default_nettype none

module ugc_classify
  import ugc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire ugc_thr_t thr,
  input  wire ugc_in_t item,
  input  wire logic    fire,
  output      ugc_out_t res
);

  logic       prev_up_level;
  logic       prev_down_level;
  logic [1:0] up_count;
  logic [1:0] down_count;
  logic       seen_sample;
  logic       decided;

  logic       prev_up_level_next;
  logic       prev_down_level_next;
  logic [1:0] up_count_next;
  logic [1:0] down_count_next;
  logic       seen_sample_next;
  logic       decided_next;

  logic       u;
  logic       d;
  logic       down_inc;
  logic       up_inc;
  logic [1:0] up_sum;
  logic [1:0] down_sum;

  always_comb begin
    // Hysteresis: a low level needs to exceed the high threshold, a high level
    // drops only below the low threshold.
    u = prev_up_level   ? !(item.up_reading   < thr.low) : (item.up_reading   > thr.high);
    d = prev_down_level ? !(item.down_reading < thr.low) : (item.down_reading > thr.high);

    down_inc = (d && !prev_down_level && !u) || (!d && prev_down_level && u);
    up_inc   = !down_inc &&
               ((u && !prev_up_level && !d) || (!u && prev_up_level && d));

    // Counts sit at 0 or 1 between items, so the sums never wrap.
    up_sum   = up_count   + {1'b0, up_inc};
    down_sum = down_count + {1'b0, down_inc};

    prev_up_level_next   = prev_up_level;
    prev_down_level_next = prev_down_level;
    up_count_next        = up_count;
    down_count_next      = down_count;
    seen_sample_next     = seen_sample;
    decided_next         = decided;
    res.event_res        = 1'b0;
    res.gesture          = GEST_NONE;

    case (item.func)
      FUNC_SAMPLE: begin
        prev_up_level_next   = u;
        prev_down_level_next = d;
        seen_sample_next     = 1'b1;
        up_count_next        = up_sum;
        down_count_next      = down_sum;
        if (down_sum >= DECIDE_COUNT) begin
          res.event_res = 1'b1;
          res.gesture   = GEST_DOWN;
        end else if (up_sum >= DECIDE_COUNT) begin
          res.event_res = 1'b1;
          res.gesture   = GEST_UP;
        end
        if (res.event_res) begin
          decided_next    = 1'b1;
          up_count_next   = 2'd0;
          down_count_next = 2'd0;
        end
      end
      FUNC_END: begin
        if (seen_sample && !decided) begin
          if (up_count > down_count) begin
            res.event_res = 1'b1;
            res.gesture   = GEST_UP;
          end else if (up_count < down_count) begin
            res.event_res = 1'b1;
            res.gesture   = GEST_DOWN;
          end
        end
        prev_up_level_next   = 1'b0;
        prev_down_level_next = 1'b0;
        up_count_next        = 2'd0;
        down_count_next      = 2'd0;
        seen_sample_next     = 1'b0;
        decided_next         = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_up_level   <= 1'b0;
      prev_down_level <= 1'b0;
      up_count        <= 2'd0;
      down_count      <= 2'd0;
      seen_sample     <= 1'b0;
      decided         <= 1'b0;
    end else if (fire) begin
      prev_up_level   <= prev_up_level_next;
      prev_down_level <= prev_down_level_next;
      up_count        <= up_count_next;
      down_count      <= down_count_next;
      seen_sample     <= seen_sample_next;
      decided         <= decided_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/updown_gesture_classifier_top.sv -----
// Top level of the up/down gesture classifier: input register, classifier,
// result register and threshold registers.
// Depends on ugc_pkg, ugc_cfg_regs and ugc_classify.
//
// Usage:
//   sample channel (sample_valid, sample_stall, sample) takes one item per
//   transaction: a photodiode sample pair or an end-of-stream marker.
//   result channel (result_valid, result_stall, result) gives exactly one
//   result per item, in order: event_res and a gesture code.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the high
//   threshold (index 0) or low threshold (index 1); cfg_ready is always high.
//   Write thresholds only while no item is in flight.
// Timing: an accepted item is classified from the input register and its
//   result is then loaded into the result register, which a result stall
//   can hold off; an item passes two register stages in all. The block
//   takes one item per cycle while sample_stall is low; the rate is set by
//   the single pass through the classifier between the two registers.
// Reset (rst, synchronous) empties both registers, clears the stream state
//   and restores the thresholds to 64 and 32.
// While result_stall holds, the result stays put, one more item can wait in
//   the input register, and then sample_stall rises.
`default_nettype none

module updown_gesture_classifier_top
  import ugc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output      logic                 sample_stall,
  input  wire ugc_in_t              sample,
  output      logic                 result_valid,
  input  wire logic                 result_stall,
  output      ugc_out_t             result,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  ugc_thr_t thr;
  ugc_in_t  item;
  logic     item_valid;
  ugc_out_t res;
  logic     advance;
  logic     fire;

  ugc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  ugc_classify u_cls (
    .clk  (clk),
    .rst  (rst),
    .thr  (thr),
    .item (item),
    .fire (fire),
    .res  (res)
  );

  // The result register can take a new value when empty or being drained.
  assign advance      = !result_valid || !result_stall;
  assign fire         = item_valid && advance;
  assign sample_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!sample_stall) begin
      item_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      item <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ugc_checker.sv -----
// Port-level checker for the up/down gesture classifier, bound to the top level.
// Depends on ugc_pkg for gesture codes.
`default_nettype none

module ugc_checker
  import ugc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     sample_stall,
  input wire logic     result_valid,
  input wire logic     result_stall,
  input wire ugc_out_t result
);

  // A stalled result stays valid and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // An event always carries a real gesture, a non-event carries none, and every code is legal.
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.event_res == (result.gesture != GEST_NONE)) &&
                     (result.gesture == GEST_NONE || result.gesture == GEST_UP ||
                      result.gesture == GEST_DOWN))
    else $error("event flag and gesture code disagree");

  // With the output free, the input side never holds off a new transaction.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !sample_stall)
    else $error("input stalled while result register is empty");

endmodule

bind updown_gesture_classifier_top ugc_checker u_ugc_checker (.*);

`default_nettype wire
